@@ hw/rtl/matrix_4x4_multiply_top_macros.svh @@
// Assertion macros for the 4x4 matrix multiplier.
// Used by matrix_4x4_multiply_top; expects clk and rst_n in scope.
`ifndef MATRIX_4X4_MULTIPLY_TOP_MACROS_SVH
`define MATRIX_4X4_MULTIPLY_TOP_MACROS_SVH

// same-cycle implication
`define MM4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MM4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mm4_pkg.sv @@
// Shared types and constants for the 4x4 matrix multiplier.
// No dependencies; used by mm4_ctrl, mm4_datapath and the top level.
package mm4_pkg;

  localparam int DIM      = 4;
  localparam int IDX_W    = $clog2(DIM);
  localparam int CELL_W   = 2 * IDX_W;
  localparam int CELLS    = DIM * DIM;
  localparam int DATA_W   = 32;
  localparam int FRAC     = 16;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int TERM_W   = PROD_W - FRAC;
  localparam int ACC_W    = TERM_W + $clog2(DIM);
  localparam int TDATA_W  = 40;
  localparam int REQ_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_LEFT  = 2'd0,
    REQ_LOAD_RIGHT = 2'd1,
    REQ_COMPUTE    = 2'd2,
    REQ_NONE       = 2'd3
  } req_t;

  // controller -> datapath
  typedef struct packed {
    logic             wr_left;
    logic             wr_right;
    logic             mul_en;
    logic             acc_en;
    logic             acc_first;
    logic             out_load;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } sts_t;

  // identity matrix element, 1.0 on the diagonal
  function automatic logic signed [DATA_W-1:0] identity_elem(input logic [CELL_W-1:0] idx);
    logic signed [DATA_W-1:0] one;
    one = DATA_W'(1) << FRAC;
    return (idx[CELL_W-1:IDX_W] == idx[IDX_W-1:0]) ? one : '0;
  endfunction

endpackage

@@ hw/rtl/matrix_4x4_multiply_top.sv @@
// 4x4 signed Q16.16 matrix multiplier with chained product (top level).
// Holds a left and a right matrix, both identity after reset. A request with
// tuser = load-left or load-right writes one element into its store. A compute
// request forms left x right: each element is built by one shared 32x32
// multiplier and a 50-bit accumulator over four terms (product shifted right
// by 16, floor), saturated to 32 bits, then sent in row-major order with
// tlast on the sixteenth. Each element passes the multiply-add sequencer's
// multiply, final-add and output states, and waits there on any output stall;
// the input is not ready meanwhile. After the last element the product has
// replaced the left store, so a following compute chains the transform.
// Depends on mm4_pkg, mm4_ctrl, mm4_datapath and the macro header.
`include "matrix_4x4_multiply_top_macros.svh"

module matrix_4x4_multiply_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mm4_pkg::TDATA_W-1:0]   in_tdata,   // row[1:0], col[3:2], value[35:4], zero pad
  input  logic [mm4_pkg::REQ_W-1:0]     in_tuser,   // req_type[1:0]
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mm4_pkg::TDATA_W-1:0]   out_tdata,  // row_res[1:0], col_res[3:2],
                                                    // value_res[35:4], zero pad
  output logic                          out_tlast   // last
);

  mm4_pkg::cmd_t cmd;
  mm4_pkg::sts_t sts;

  // sequencer: decodes requests, walks row, column and term index
  mm4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores, multiply-accumulate, saturation and output register
  mm4_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // a compute request closes the input until the product is out
  `MM4_ASSERT_NEXT(a_compute_blocks, in_tvalid && in_tready && (in_tuser == mm4_pkg::REQ_COMPUTE), !in_tready, "input still ready after compute request")
  // a pending result is never overwritten
  `MM4_ASSERT_NOW(a_no_overwrite, cmd.out_load, sts.out_free, "result loaded over a pending one")
  // no store write while the multiplier is busy
  `MM4_ASSERT_NOW(a_no_load_in_compute, cmd.mul_en, !in_tready && !cmd.wr_left && !cmd.wr_right, "store written during compute")

endmodule

@@ hw/rtl/mm4_ctrl.sv @@
// Sequencer for the 4x4 matrix multiplier: request decode and r/c/k loop.
// Depends on mm4_pkg.
module mm4_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mm4_pkg::REQ_W-1:0]     in_tuser,
  input  mm4_pkg::sts_t                 sts,
  output mm4_pkg::cmd_t                 cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_LAST = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [mm4_pkg::IDX_W-1:0]  r_r, r_nxt;
  logic [mm4_pkg::IDX_W-1:0]  c_r, c_nxt;
  logic [mm4_pkg::IDX_W-1:0]  k_r, k_nxt;
  logic                       accept;
  logic                       last_elem;

  localparam logic [mm4_pkg::IDX_W-1:0] IDX_MAX = mm4_pkg::IDX_W'(mm4_pkg::DIM - 1);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign last_elem = (r_r == IDX_MAX) && (c_r == IDX_MAX);

  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    cmd           = '0;
    cmd.row       = r_r;
    cmd.col       = c_r;
    cmd.k         = k_r;
    cmd.last      = last_elem;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (mm4_pkg::req_t'(in_tuser))
            mm4_pkg::REQ_LOAD_LEFT:  cmd.wr_left  = 1'b1;
            mm4_pkg::REQ_LOAD_RIGHT: cmd.wr_right = 1'b1;
            mm4_pkg::REQ_COMPUTE: begin
              state_nxt = S_MUL;
              r_nxt     = '0;
              c_nxt     = '0;
              k_nxt     = '0;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul_en    = 1'b1;
        cmd.acc_en    = (k_r != '0);
        cmd.acc_first = (k_r == mm4_pkg::IDX_W'(1));
        k_nxt         = k_r + 1'b1;
        if (k_r == IDX_MAX) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          c_nxt        = c_r + 1'b1;
          if (c_r == IDX_MAX) begin
            r_nxt = r_r + 1'b1;
          end
          state_nxt = last_elem ? S_IDLE : S_MUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

@@ hw/rtl/mm4_datapath.sv @@
// Datapath for the 4x4 matrix multiplier: stores, multiplier, accumulator,
// saturation, row buffer and output register. Depends on mm4_pkg.
module mm4_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mm4_pkg::TDATA_W-1:0]     in_tdata,
  input  mm4_pkg::cmd_t                   cmd,
  output mm4_pkg::sts_t                   sts,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mm4_pkg::TDATA_W-1:0]     out_tdata,
  output logic                            out_tlast
);

  localparam int IW = mm4_pkg::IDX_W;
  localparam int DW = mm4_pkg::DATA_W;

  logic signed [DW-1:0]               left_r  [mm4_pkg::CELLS];
  logic signed [DW-1:0]               right_r [mm4_pkg::CELLS];
  logic signed [DW-1:0]               rowbuf_r [mm4_pkg::DIM];
  logic signed [mm4_pkg::PROD_W-1:0]  prod_r;
  logic signed [mm4_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic                               out_valid_r;
  logic [IW-1:0]                      out_row_r, out_col_r;
  logic signed [DW-1:0]               out_val_r;
  logic                               out_last_r;

  logic [IW-1:0]                      ld_row, ld_col;
  logic signed [DW-1:0]               ld_val;
  logic signed [DW-1:0]               mul_a, mul_b;
  logic signed [mm4_pkg::TERM_W-1:0]  term;
  logic signed [DW-1:0]               sat_val;
  logic                               no_ovf;

  assign ld_row = in_tdata[IW-1:0];
  assign ld_col = in_tdata[2*IW-1:IW];
  assign ld_val = in_tdata[2*IW+DW-1:2*IW];

  assign mul_a = left_r[{cmd.row, cmd.k}];
  assign mul_b = right_r[{cmd.k, cmd.col}];

  // arithmetic shift right of the product == floor
  assign term    = prod_r[mm4_pkg::PROD_W-1:mm4_pkg::FRAC];
  assign acc_nxt = (cmd.acc_first ? mm4_pkg::ACC_W'(0) : acc_r) + mm4_pkg::ACC_W'(term);

  // in range when every bit above bit 31 matches the sign
  assign no_ovf  = (acc_r[mm4_pkg::ACC_W-1:DW-1] == '0) || (acc_r[mm4_pkg::ACC_W-1:DW-1] == '1);
  assign sat_val = no_ovf ? acc_r[DW-1:0]
                 : (acc_r[mm4_pkg::ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});

  assign sts.out_free = !out_valid_r || out_tready;

  // stores; the finished product row goes back into the left store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mm4_pkg::CELLS; i++) begin
        left_r[i]  <= mm4_pkg::identity_elem(mm4_pkg::CELL_W'(i));
        right_r[i] <= mm4_pkg::identity_elem(mm4_pkg::CELL_W'(i));
      end
    end else begin
      if (cmd.wr_left) begin
        left_r[{ld_row, ld_col}] <= ld_val;
      end
      if (cmd.wr_right) begin
        right_r[{ld_row, ld_col}] <= ld_val;
      end
      if (cmd.out_load && (cmd.col == IW'(mm4_pkg::DIM - 1))) begin
        for (int j = 0; j < mm4_pkg::DIM; j++) begin
          left_r[{cmd.row, IW'(j)}] <= (j == mm4_pkg::DIM - 1) ? sat_val : rowbuf_r[IW'(j)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.out_load) begin
      rowbuf_r[cmd.col] <= sat_val;
      out_row_r         <= cmd.row;
      out_col_r         <= cmd.col;
      out_val_r         <= sat_val;
      out_last_r        <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(mm4_pkg::TDATA_W - 2*IW - DW)'(0), out_val_r, out_col_r, out_row_r};

endmodule
